// ----- src/ial_pkg.sv -----
// Package: shared types, codes and constants for the indexed array list.
`timescale 1ns / 1ps
package ial_pkg;

    localparam int IAL_DEPTH     = 32;
    localparam int CNT_W         = 7;
    localparam int DATA_W        = 32;
    localparam int CAP_W         = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         position;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [4:0]         read_index;
        logic               has_value;
        logic [5:0]         entry_count;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [5:0]        pos;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- src/ial_cell.sv -----
// One list cell: holds one entry and takes a neighbor's entry on shift or rotate.
`timescale 1ns / 1ps
module ial_cell
    import ial_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    input  logic [DATA_W-1:0] wrap_data,
    output logic [DATA_W-1:0] data
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_C1 = CNT_W'(IDX + 1);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [CNT_W-1:0]  pos_c;

    assign pos_c = CNT_W'(ctrl.pos);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (IDX_C == pos_c)
                begin
                    entry_next = ctrl.value;
                end
                else if (IDX_C > pos_c)
                begin
                    entry_next = left_data;
                end
            end
            CELL_DEL:
            begin
                if (IDX_C >= pos_c)
                begin
                    entry_next = right_data;
                end
            end
            CELL_ROT:
            begin
                if (IDX_C1 < ctrl.cnt)
                begin
                    entry_next = right_data;
                end
                else if (IDX_C1 == ctrl.cnt)
                begin
                    entry_next = wrap_data;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

// ----- src/ial_row.sv -----
// Row of list cells chained to their neighbors; cell 0 is the list head.
`timescale 1ns / 1ps
module ial_row
    import ial_pkg::*;
#(
    parameter int LIST_DEPTH = IAL_DEPTH
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    output logic [DATA_W-1:0] head
);

    logic [DATA_W-1:0] cell_data [LIST_DEPTH];

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;

            if (g == 0)
            begin : g_first
                assign left_d = ctrl.value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[g-1];
            end

            if (g == LIST_DEPTH - 1)
            begin : g_end
                assign right_d = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[g+1];
            end

            ial_cell #(
                .IDX (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_data  (left_d),
                .right_data (right_d),
                .wrap_data  (cell_data[0]),
                .data       (cell_data[g])
            );
        end
    endgenerate

    assign head = cell_data[0];

endmodule

// ----- src/indexed_array_list_top.sv -----
// Top level: command decode, count and capacity, read streaming and result register.
//
//  channel   dir  handshake                  word
//  command   in   start && !busy             cmd    (in_word_t)
//  result    out  result_valid, one cycle    result (out_word_t)
//  capacity  in   cfg_we                     cfg_wdata
//
// Every accepted word gives its first result on the next cycle.
// Insert, delete, clear: one result each; insert and delete shift the cell row as the word is taken.
// Read all: one entry per cycle as the row rotates through cell 0;
// busy stays high until the last entry is out.
// Reset clears count, capacity to 32 and the sequencer; entries are not cleared.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
module indexed_array_list_top
    import ial_pkg::*;
#(
    parameter int LIST_DEPTH = IAL_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_word_t         cmd,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    output logic             result_valid,
    output out_word_t        result
);

    localparam int RIW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic             state_reg,   state_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CAP_W-1:0] cap_reg;
    logic [RIW-1:0]   rd_idx_reg,  rd_idx_next;
    logic             result_valid_reg, result_valid_next;
    out_word_t        result_reg,  result_next;

    logic [CNT_W-1:0] cap_c;
    logic [CNT_W-1:0] cap_now;
    logic [CNT_W-1:0] pos_c;
    logic [CNT_W-1:0] rd_idx_c;
    logic             accept;
    cell_ctrl_t       cell_ctrl;
    logic [DATA_W-1:0] head;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg == S_READ);
    assign cap_c    = CNT_W'(cap_reg);
    assign cap_now  = (cap_c < DEPTH_C) ? cap_c : DEPTH_C;
    assign pos_c    = CNT_W'(cmd.position);
    assign rd_idx_c = CNT_W'(rd_idx_reg);

    ial_row #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_row (
        .clk  (clk),
        .ctrl (cell_ctrl),
        .head (head)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rd_idx_next       = rd_idx_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        cell_ctrl.op      = CELL_HOLD;
        cell_ctrl.pos     = cmd.position;
        cell_ctrl.cnt     = count_reg;
        cell_ctrl.value   = cmd.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_valid_next       = 1'b1;
                    result_next.status      = STAT_OK;
                    result_next.read_value  = '0;
                    result_next.read_index  = '0;
                    result_next.has_value   = 1'b0;
                    result_next.entry_count = count_reg[5:0];
                    result_next.last        = 1'b1;
                    unique case (cmd.action)
                        ACT_INSERT:
                        begin
                            if (count_reg >= cap_now)
                            begin
                                result_next.status = STAT_FULL;
                            end
                            else if (pos_c > count_reg)
                            begin
                                result_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                cell_ctrl.op            = CELL_INS;
                                count_next              = count_reg + 1'b1;
                                result_next.entry_count = count_next[5:0];
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = STAT_EMPTY;
                            end
                            else if (pos_c >= count_reg)
                            begin
                                result_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                cell_ctrl.op            = CELL_DEL;
                                count_next              = count_reg - 1'b1;
                                result_next.entry_count = count_next[5:0];
                            end
                        end
                        ACT_READ:
                        begin
                            if (count_reg != '0)
                            begin
                                cell_ctrl.op           = CELL_ROT;
                                result_next.read_value = head;
                                result_next.has_value  = 1'b1;
                                if (count_reg != CNT_W'(1))
                                begin
                                    result_next.last = 1'b0;
                                    rd_idx_next      = RIW'(1);
                                    state_next       = S_READ;
                                end
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next              = '0;
                            result_next.entry_count = '0;
                        end
                        default:
                        begin
                            result_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cell_ctrl.op            = CELL_ROT;
                result_valid_next       = 1'b1;
                result_next.status      = STAT_OK;
                result_next.read_value  = head;
                result_next.read_index  = rd_idx_c[4:0];
                result_next.has_value   = 1'b1;
                result_next.entry_count = count_reg[5:0];
                result_next.last        = 1'b0;
                rd_idx_next             = rd_idx_reg + 1'b1;
                if (rd_idx_c + 1'b1 == count_reg)
                begin
                    result_next.last = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            cap_reg          <= CAP_RESET;
            rd_idx_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rd_idx_reg       <= rd_idx_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above list depth");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> result_valid)
        else $error("accepted word gave no result");

    a_stream_cont: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (result_valid && result.has_value))
        else $error("read stream gap");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("busy after last result");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (rd_idx_c < count_reg))
        else $error("read index past count");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for indexed_array_list_top: directed and random commands against a shadow list.
`timescale 1ns / 1ps
module tb_top;
    import ial_pkg::*;

    localparam int LIMIT_CYCLES = 300000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    in_word_t         cmd       = '0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             busy;
    logic             result_valid;
    out_word_t        result;

    // shadow copy of the list
    logic signed [31:0] shadow_list [IAL_DEPTH];
    int                 shadow_len = 0;
    int                 shadow_cap = 32;

    out_word_t pending_results [$];
    int        err_count = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;

    indexed_array_list_top #(
        .LIST_DEPTH (IAL_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic in_word_t cmd_word(logic [1:0] act, logic [5:0] pos, logic [31:0] val);
        in_word_t w;
        w.action   = act;
        w.position = pos;
        w.value    = val;
        return w;
    endfunction

    // Expected results for one accepted word; updates the shadow list.
    task automatic apply_list_action(in_word_t w);
        out_word_t r;
        int        lim;
        int        p;
        r      = '0;
        r.last = 1'b1;
        lim    = (shadow_cap < IAL_DEPTH) ? shadow_cap : IAL_DEPTH;
        p      = w.position;
        case (w.action)
            ACT_INSERT:
            begin
                if (shadow_len >= lim)
                    r.status = STAT_FULL;
                else if (p > shadow_len)
                    r.status = STAT_RANGE;
                else
                begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = w.value;
                    shadow_len++;
                    r.status = STAT_OK;
                end
                r.entry_count = 6'(shadow_len);
                pending_results.push_back(r);
            end
            ACT_DELETE:
            begin
                if (shadow_len == 0)
                    r.status = STAT_EMPTY;
                else if (p >= shadow_len)
                    r.status = STAT_RANGE;
                else
                begin
                    for (int i = p + 1; i < shadow_len; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_len--;
                    r.status = STAT_OK;
                end
                r.entry_count = 6'(shadow_len);
                pending_results.push_back(r);
            end
            ACT_READ:
            begin
                if (shadow_len == 0)
                    pending_results.push_back(r);
                else
                begin
                    for (int i = 0; i < shadow_len; i++)
                    begin
                        r.status      = STAT_OK;
                        r.read_value  = shadow_list[i];
                        r.read_index  = 5'(i);
                        r.has_value   = 1'b1;
                        r.entry_count = 6'(shadow_len);
                        r.last        = (i == shadow_len - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            default:
            begin
                shadow_len = 0;
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Drive one word and wait until it is taken.
    task automatic send_word(in_word_t w);
        if (idle_on && $urandom_range(0, 99) < 25)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        apply_list_action(w);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_cap = v;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t unexpected word: expected none actual %h", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("read_value", want.read_value, result.read_value);
                check_field("read_index", 32'(want.read_index), 32'(result.read_index));
                check_field("has_value", 32'(want.has_value), 32'(result.has_value));
                check_field("entry_count", 32'(want.entry_count),
                            32'(result.entry_count));
                check_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    task automatic test_empty_list();
        send_word(cmd_word(ACT_READ, 6'd0, 32'd0));
        send_word(cmd_word(ACT_DELETE, 6'd0, 32'd0));
        send_word(cmd_word(ACT_DELETE, 6'd63, 32'hffff_ffff));
        send_word(cmd_word(ACT_INSERT, 6'd1, 32'd5));
        send_word(cmd_word(ACT_INSERT, 6'd63, 32'd6));
    endtask

    task automatic test_insert_delete();
        send_word(cmd_word(ACT_INSERT, 6'd0, 32'h7fff_ffff));
        send_word(cmd_word(ACT_INSERT, 6'd0, 32'h8000_0000));
        send_word(cmd_word(ACT_INSERT, 6'd2, 32'hffff_ffff));
        send_word(cmd_word(ACT_INSERT, 6'd1, 32'd0));
        send_word(cmd_word(ACT_READ, 6'd0, 32'd0));
        send_word(cmd_word(ACT_DELETE, 6'd4, 32'd0));
        send_word(cmd_word(ACT_DELETE, 6'd3, 32'd0));
        send_word(cmd_word(ACT_DELETE, 6'd0, 32'd0));
        send_word(cmd_word(ACT_READ, 6'd0, 32'd0));
    endtask

    // capacity below count, zero capacity, capacity above depth
    task automatic test_capacity_limits();
        write_capacity(6'd1);
        send_word(cmd_word(ACT_INSERT, 6'd0, 32'd11));
        send_word(cmd_word(ACT_DELETE, 6'd63, 32'd0));
        send_word(cmd_word(ACT_DELETE, 6'd1, 32'd0));
        send_word(cmd_word(ACT_INSERT, 6'd0, 32'd12));
        write_capacity(6'd0);
        send_word(cmd_word(ACT_INSERT, 6'd0, 32'd13));
        send_word(cmd_word(ACT_CLEAR, 6'd0, 32'd0));
        send_word(cmd_word(ACT_INSERT, 6'd0, 32'd14));
        send_word(cmd_word(ACT_READ, 6'd0, 32'd0));
        write_capacity(6'd63);
        send_word(cmd_word(ACT_INSERT, 6'd0, 32'h1234_5678));
        send_word(cmd_word(ACT_READ, 6'd0, 32'd0));
    endtask

    task automatic test_random_mix(int n_items, logic [CAP_W-1:0] cap, bit gaps);
        in_word_t w;
        int       r;
        write_capacity(cap);
        idle_on = gaps;
        for (int k = 0; k < n_items; k++)
        begin
            r          = $urandom_range(0, 99);
            w.value    = $urandom;
            w.position = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: w.value = 32'h8000_0000;
                    1: w.value = 32'h7fff_ffff;
                    2: w.value = 32'h0000_0000;
                    default: w.value = 32'hffff_ffff;
                endcase
            end
            if (r < 62)
            begin
                w.action = ACT_INSERT;
                if (r >= 4)
                    w.position = 6'($urandom_range(0, shadow_len));
            end
            else if (r < 84)
            begin
                w.action = ACT_DELETE;
                if (r >= 66 && shadow_len > 0)
                    w.position = 6'($urandom_range(0, shadow_len - 1));
            end
            else if (r < 93)
                w.action = ACT_READ;
            else if (r < 95)
                w.action = ACT_CLEAR;
            else
                w.action = 2'($urandom_range(0, 3));
            send_word(w);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_insert_delete();
        test_capacity_limits();
        test_random_mix(90, 6'd32, 1'b1);
        test_random_mix(100, 6'd63, 1'b0);
        test_random_mix(40, 6'd1, 1'b1);
        test_random_mix(50, 6'd5, 1'b1);
        test_random_mix(20, 6'd0, 1'b1);
        test_random_mix(50, 6'd17, 1'b1);
        test_random_mix(55, 6'd32, 1'b1);
        wait_idle();
        repeat (5) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- indexed_array_list_top.f -----
src/ial_pkg.sv
src/ial_cell.sv
src/ial_row.sv
src/indexed_array_list_top.sv
verif/tb_top.sv
